@@ sv/fixed_point_alu_macros.svh @@
// assertion macros for the fixed-point alu
// included by the top level, no other dependencies
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// same-cycle implication, reset disables the check
`define FPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fixed_point_alu check failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fixed_point_alu check failed");

`endif

@@ sv/fpa_pkg.sv @@
// shared constants and action codes for the fixed-point alu
// no dependencies
package fpa_pkg;
	typedef enum logic [3:0] {
		ACT_ADD = 4'd0,
		ACT_SUB = 4'd1,
		ACT_MUL = 4'd2,
		ACT_DIV = 4'd3,
		ACT_MIN = 4'd4,
		ACT_MAX = 4'd5,
		ACT_CMP = 4'd6,
		ACT_INC = 4'd7,
		ACT_DEC = 4'd8
	} action_t;

	// quotient bits resolved per divider stage
	localparam int DIV_STEPS = 2;
endpackage

@@ sv/fixed_point_alu.sv @@
// signed fixed-point alu top level: entry stage, multiplier, divider pipeline, result stage
// depends on fpa_pkg, fpa_div_stage and fixed_point_alu_macros.svh
//
// usage:
//   input channel in_valid/in_ready carries action, operand_a, operand_b per beat
//   output channel out_valid/out_ready carries result_value and the five flags
//   every action (add, sub, mul, div, min, max, compare, inc, dec) takes the same
//   path, so results leave in the order the beats came in
//   the pipeline depth is set by the restoring divider, two quotient bits per stage
//   throughput: one beat per cycle while the output is not stalled; the multiplier is two registered partial
//   products that run beside the first divider stages
//   products and quotients round half away from zero, overflow saturates and
//   raises overflowed, a zero divisor gives 0 with divide_by_zero
//   reset clears all stage valid bits; the pipe is empty afterwards
//   when the receiver stalls the whole pipe holds, in_ready drops only while the
//   last stage is full and out_ready is low
`include "fixed_point_alu_macros.svh"
module fixed_point_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS  = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [3:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] result_value,
	output logic                         is_less,
	output logic                         is_equal,
	output logic                         is_greater,
	output logic                         overflowed,
	output logic                         divide_by_zero
);
	localparam int DW  = DATA_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int QW  = DW + FB;
	localparam int H   = (DW + 1) / 2;
	localparam int NDS = (QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NST = NDS + 2;

	localparam logic [DW-1:0]   MAX_V  = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0]   MIN_V  = {1'b1, {(DW-1){1'b0}}};
	localparam logic [2*DW-1:0] SIGN_W = (2*DW)'(1) << (DW - 1);
	localparam logic [2*DW-1:0] RND_W  = (2*DW)'(1) << (FB - 1);

	typedef struct packed {
		logic [3:0]        act;
		logic              lt;
		logic              eq;
		logic              gt;
		logic              neg;
		logic              ovf;
		logic              dz;
		logic [DW-1:0]     res;
		logic [DW-1:0]     mb;
		logic [DW+H-1:0]   pp0;
		logic [2*DW-H-1:0] pp1;
		logic [2*DW-1:0]   prod;
		logic [DW:0]       rem;
		logic [QW-1:0]     num;
	} stage_t;

	stage_t pl  [NST];
	stage_t nxt [NST];
	logic   vld [NST];
	logic   en;

	// {overflow, value} of a wide sum clamped to the data range
	function automatic logic [DW:0] sat_sum(input logic [DW:0] s);
		logic o;
		o = s[DW] ^ s[DW-1];
		return {o, o ? (s[DW] ? MIN_V : MAX_V) : s[DW-1:0]};
	endfunction

	// {overflow, value} of a signed magnitude clamped to the data range
	function automatic logic [DW:0] sat_mag(input logic [2*DW-1:0] m, input logic n);
		logic [DW-1:0] v;
		v = m[DW-1:0];
		if (n) begin
			if (m > SIGN_W) return {1'b1, MIN_V};
			return {1'b0, -v};
		end
		if (m >= SIGN_W) return {1'b1, MAX_V};
		return {1'b0, v};
	endfunction

	assign en       = !vld[NST-1] || out_ready;
	assign in_ready = en;

	// entry stage: flags, magnitudes and the results of add, sub, inc, dec, min and max
	always_comb begin
		logic [DW:0]   ea;
		logic [DW:0]   eb;
		logic [DW:0]   sr;
		logic [DW-1:0] ma;
		ea = {operand_a[DW-1], operand_a};
		eb = {operand_b[DW-1], operand_b};
		ma = operand_a[DW-1] ? -operand_a : operand_a;
		nxt[0]      = '0;
		nxt[0].act  = action;
		nxt[0].lt   = operand_a < operand_b;
		nxt[0].eq   = operand_a == operand_b;
		nxt[0].gt   = operand_a > operand_b;
		nxt[0].neg  = operand_a[DW-1] ^ operand_b[DW-1];
		nxt[0].mb   = operand_b[DW-1] ? -operand_b : operand_b;
		nxt[0].num  = {ma, {FB{1'b0}}};
		nxt[0].dz   = (action_t'(action) == ACT_DIV) && (operand_b == '0);
		sr          = {1'b0, operand_a};
		unique case (action_t'(action))
			ACT_ADD: sr = sat_sum(ea + eb);
			ACT_SUB: sr = sat_sum(ea - eb);
			ACT_INC: sr = sat_sum(ea + (DW+1)'(1));
			ACT_DEC: sr = sat_sum(ea - (DW+1)'(1));
			ACT_MIN: sr = {1'b0, (operand_a < operand_b) ? operand_a : operand_b};
			ACT_MAX: sr = {1'b0, (operand_a > operand_b) ? operand_a : operand_b};
			default: sr = {1'b0, operand_a};
		endcase
		nxt[0].ovf = sr[DW];
		nxt[0].res = sr[DW-1:0];
	end

	for (genvar k = 1; k < NST; k++) begin : g_st
		if (k <= NDS) begin : g_div
			localparam int LEFT = QW - (k - 1) * DIV_STEPS;
			localparam int ST   = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;
			logic [DW:0]   rem_o;
			logic [QW-1:0] num_o;

			fpa_div_stage #(.DW(DW), .QW(QW), .STEPS(ST)) u_div (
				.divisor (pl[k-1].mb),
				.rem_in  (pl[k-1].rem),
				.num_in  (pl[k-1].num),
				.rem_out (rem_o),
				.num_out (num_o)
			);

			always_comb begin
				nxt[k]     = pl[k-1];
				nxt[k].rem = rem_o;
				nxt[k].num = num_o;
				if (k == 1) begin
					nxt[k].pp0 = (DW+H)'(pl[k-1].num[QW-1:FB]) * (DW+H)'(pl[k-1].mb[H-1:0]);
					nxt[k].pp1 = (2*DW-H)'(pl[k-1].num[QW-1:FB])
						* (2*DW-H)'(pl[k-1].mb[DW-1:H]);
				end
				if (k == 2) begin
					nxt[k].prod = (((2*DW)'(pl[k-1].pp1) << H) + (2*DW)'(pl[k-1].pp0)
						+ RND_W) >> FB;
				end
			end
		end else begin : g_fin
			// result stage: quotient rounding and saturation of products and quotients
			always_comb begin
				logic [QW:0]   qr;
				logic [DW:0]   sm;
				logic          up;
				nxt[k] = pl[k-1];
				up = {pl[k-1].rem[DW-1:0], 1'b0} >= {1'b0, pl[k-1].mb};
				qr = {1'b0, pl[k-1].num} + (QW+1)'(up);
				sm = {pl[k-1].ovf, pl[k-1].res};
				unique case (action_t'(pl[k-1].act))
					ACT_MUL: sm = sat_mag(pl[k-1].prod, pl[k-1].neg);
					ACT_DIV: sm = pl[k-1].dz ? '0 : sat_mag((2*DW)'(qr), pl[k-1].neg);
					default: sm = {pl[k-1].ovf, pl[k-1].res};
				endcase
				nxt[k].ovf = sm[DW];
				nxt[k].res = sm[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_valid;
			for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NST; i++) pl[i] <= nxt[i];
		end
	end

	assign out_valid      = vld[NST-1];
	assign result_value   = pl[NST-1].res;
	assign is_less        = pl[NST-1].lt;
	assign is_equal       = pl[NST-1].eq;
	assign is_greater     = pl[NST-1].gt;
	assign overflowed     = pl[NST-1].ovf;
	assign divide_by_zero = pl[NST-1].dz;

	`FPA_ASSERT_IMPL(a_cmp_onehot, clk, arst_n, out_valid,
		$onehot({is_less, is_equal, is_greater}))
	`FPA_ASSERT_IMPL(a_dz_zero, clk, arst_n, out_valid && divide_by_zero,
		result_value == '0 && !overflowed)
	`FPA_ASSERT_IMPL(a_ovf_bound, clk, arst_n, out_valid && overflowed,
		result_value == MAX_V || result_value == MIN_V)
	`FPA_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(result_value))
endmodule

@@ sv/fpa_div_stage.sv @@
// STEPS restoring-division steps for one divider pipeline stage
// depends on fpa_pkg
module fpa_div_stage import fpa_pkg::*; #(
	parameter int DW    = 32,
	parameter int QW    = 40,
	parameter int STEPS = DIV_STEPS
) (
	input  logic [DW-1:0] divisor,
	input  logic [DW:0]   rem_in,
	input  logic [QW-1:0] num_in,
	output logic [DW:0]   rem_out,
	output logic [QW-1:0] num_out
);
	always_comb begin
		logic [DW:0]   r;
		logic [QW-1:0] n;
		logic [DW:0]   t;
		r = rem_in;
		n = num_in;
		for (int i = 0; i < STEPS; i++) begin
			// numerator msb shifts into the remainder, quotient bit shifts into the lsb
			t = {r[DW-1:0], n[QW-1]};
			if (t >= {1'b0, divisor}) begin
				r = t - {1'b0, divisor};
				n = {n[QW-2:0], 1'b1};
			end else begin
				r = t;
				n = {n[QW-2:0], 1'b0};
			end
		end
		rem_out = r;
		num_out = n;
	end
endmodule

@@ bench/fixed_point_alu_tb.sv @@
// testbench for fixed_point_alu: directed and random beats checked against an in-bench predictor
// depends on fpa_pkg and the fixed_point_alu rtl
`timescale 1ns / 100ps
module fixed_point_alu_tb;
	import fpa_pkg::*;

	localparam int FB = 8;
	localparam int DW = 32;
	localparam int LATENCY = 22;

	// codes outside the defined actions, handled like compare
	localparam logic [3:0] ACT_SPARE_LO = 4'd9;
	localparam logic [3:0] ACT_SPARE_HI = 4'd15;

	typedef struct packed {
		logic signed [DW-1:0] value;
		logic less;
		logic equal;
		logic greater;
		logic ovf;
		logic dz;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] action = '0;
	logic signed [DW-1:0] operand_a = '0;
	logic signed [DW-1:0] operand_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] result_value;
	logic is_less, is_equal, is_greater, overflowed, divide_by_zero;

	alu_result_t expected_results[$];
	int errors = 0;
	int results_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 0;
	int op_count[16];

	fixed_point_alu dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	localparam logic signed [127:0] MAXV = (128'sd1 <<< (DW - 1)) - 1;
	localparam logic signed [127:0] MINV = -(128'sd1 <<< (DW - 1));

	function automatic logic signed [DW-1:0] clamp(input logic signed [127:0] v,
			inout logic ovf);
		if (v > MAXV) begin
			ovf = 1'b1;
			return MAXV[DW-1:0];
		end
		if (v < MINV) begin
			ovf = 1'b1;
			return MINV[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	// exact rounding, half away from zero, done on magnitudes
	function automatic alu_result_t predict_alu(input logic [3:0] act,
			input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
		alu_result_t r;
		logic signed [127:0] wa, wb, m, n, d, q, rem;
		logic neg;
		logic ovf;
		wa = a;
		wb = b;
		ovf = 1'b0;
		neg = (a < 0) != (b < 0);
		r.dz = 1'b0;
		r.value = a;
		case (act)
			ACT_ADD: r.value = clamp(wa + wb, ovf);
			ACT_SUB: r.value = clamp(wa - wb, ovf);
			ACT_MUL: begin
				m = (wa < 0 ? -wa : wa) * (wb < 0 ? -wb : wb);
				m = (m + (128'sd1 <<< (FB - 1))) >>> FB;
				r.value = clamp(neg ? -m : m, ovf);
			end
			ACT_DIV: begin
				if (b == 0) begin
					r.value = '0;
					r.dz = 1'b1;
				end else begin
					n = (wa < 0 ? -wa : wa) <<< FB;
					d = wb < 0 ? -wb : wb;
					q = n / d;
					rem = n % d;
					if (rem >= d - rem) q = q + 1;
					r.value = clamp(neg ? -q : q, ovf);
				end
			end
			ACT_MIN: r.value = (a < b) ? a : b;
			ACT_MAX: r.value = (a > b) ? a : b;
			ACT_INC: r.value = clamp(wa + 1, ovf);
			ACT_DEC: r.value = clamp(wa - 1, ovf);
			default: r.value = a;
		endcase
		r.ovf = ovf;
		r.less = a < b;
		r.equal = a == b;
		r.greater = a > b;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		errors++;
		$display("mismatch %s at %0t: got %h expected %h", what, $time, got, want);
	endtask

	// valid stays up from one beat to the next unless the sender idles
	task automatic send_beat(input logic [3:0] act, input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(predict_alu(act, a, b));
		op_count[act]++;
	endtask

	// receiver ready, with random stalls and an optional long hold-off
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		alu_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", result_value, '0);
			end else begin
				e = expected_results.pop_front();
				if (result_value !== e.value)
					report_mismatch("result_value", result_value, e.value);
				if (is_less !== e.less) report_mismatch("is_less", is_less, e.less);
				if (is_equal !== e.equal) report_mismatch("is_equal", is_equal, e.equal);
				if (is_greater !== e.greater)
					report_mismatch("is_greater", is_greater, e.greater);
				if (overflowed !== e.ovf) report_mismatch("overflowed", overflowed, e.ovf);
				if (divide_by_zero !== e.dz)
					report_mismatch("divide_by_zero", divide_by_zero, e.dz);
			end
		end
	end

	function automatic logic signed [DW-1:0] rand_operand();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed($urandom_range(4095)) - 2048;
			2: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
				: 32'sh80000000 + $urandom_range(3);
			3: return $signed($urandom_range(65535)) <<< $urandom_range(16);
			default: return $signed($urandom) >>> $urandom_range(31);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [DW-1:0] mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		send_beat(ACT_ADD, mx, 1);
		send_beat(ACT_ADD, mn, -1);
		send_beat(ACT_SUB, mn, 1);
		send_beat(ACT_SUB, mx, -1);
		send_beat(ACT_MUL, mx, mx);
		send_beat(ACT_MUL, mn, mn);
		send_beat(ACT_MUL, mn, 32'sd256);
		send_beat(ACT_MUL, 32'sd1, 32'sd128);    // tie rounds away from zero
		send_beat(ACT_MUL, -32'sd1, 32'sd128);
		send_beat(ACT_DIV, 32'sd100, 0);
		send_beat(ACT_DIV, mn, -32'sd256);
		send_beat(ACT_DIV, mx, 32'sd1);
		send_beat(ACT_DIV, 32'sd1, 32'sd512);    // tie in the quotient
		send_beat(ACT_DIV, -32'sd3, 32'sd2);
		send_beat(ACT_MIN, 32'sd5, 32'sd5);
		send_beat(ACT_MAX, mn, mx);
		send_beat(ACT_CMP, mx, mn);
		send_beat(ACT_INC, mx, 0);
		send_beat(ACT_DEC, mn, 0);
		send_beat(ACT_SPARE_LO, 32'sd7, 32'sd8);
		send_beat(ACT_SPARE_HI, -32'sd1, -32'sd1);
		send_beat(ACT_ADD, 32'hffffffff, 32'h0);
	endtask

	task automatic test_random(input int count);
		repeat (count) begin
			send_beat(4'($urandom_range(15) < 13 ? $urandom_range(8) : $urandom_range(15)),
				rand_operand(), $urandom_range(15) == 0 ? 0 : rand_operand());
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1;
				repeat (80) @(posedge clk);
				recv_hold = 0;
			end
			begin
				test_random(60);
				in_valid <= 1'b0;
			end
		join
	endtask

	task automatic drain();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 36;
		recv_idle_pct = 46;
		test_directed();
		test_random(260);
		send_idle_pct = 46;
		recv_idle_pct = 36;
		test_random(260);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(260);
		test_backpressure();
		drain();
		$display("covered %0d results: add %0d sub %0d mul %0d div %0d other %0d",
			results_seen, op_count[0], op_count[1], op_count[2], op_count[3],
			results_seen - op_count[0] - op_count[1] - op_count[2] - op_count[3]);
		$display("saturation, rounding ties, zero divisor and unused codes included");
		if (errors == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
